@@ hdl/ift_pkg.sv @@
// Shared types and constants for the IPv4 fragment reassembly tracker.
// No dependencies.
package ift_pkg;

  localparam int TABLE_ENTRIES     = 16;
  localparam int LINK_HEADER_BYTES = 14;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = 17;

  localparam logic [3:0]  IP_VERSION   = 4'h4;
  localparam logic [15:0] IP_HDR_BYTES = 16'd20;
  localparam logic [15:0] DHCP_CLIENT  = 16'd68;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;

  localparam logic [1:0] CFG_LOCAL_ADDR = 2'd0;
  localparam logic [1:0] CFG_MIN_FRAME  = 2'd1;

  typedef enum logic [3:0] {
    V_BAD_VERSION = 4'd0,
    V_SHORT       = 4'd1,
    V_BAD_LENGTH  = 4'd2,
    V_BAD_ADDR    = 4'd3,
    V_DELIVER     = 4'd4,
    V_HELD        = 4'd5,
    V_COMPLETE    = 4'd6,
    V_OVERFLOW    = 4'd7,
    V_DOUBLE_LAST = 4'd8,
    V_EXCESS      = 4'd9,
    V_TABLE_FULL  = 4'd10
  } verdict_t;

  typedef enum logic [1:0] {
    R_ICMP  = 2'd0,
    R_UDP   = 2'd1,
    R_TCP   = 2'd2,
    R_OTHER = 2'd3
  } route_t;

  typedef struct packed {
    logic [3:0]  version;
    logic [15:0] total_length;
    logic [15:0] frame_size;
    logic [31:0] src_addr;
    logic [31:0] dest_address;
    logic [7:0]  protocol;
    logic [15:0] frag_word;
    logic [15:0] packet_id;
    logic [15:0] udp_dest_port;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [1:0]  route;
    logic [3:0]  slot;
    logic [15:0] frag_offset;
    logic [15:0] body_size;
    logic [15:0] reassembled_length;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_slot;
    logic             has_free;
    logic [IDX_W-1:0] free_slot;
  } lookup_t;

  typedef struct packed {
    logic             alloc;
    logic             release_entry;
    logic [IDX_W-1:0] slot;
    logic [31:0]      source;
    logic [15:0]      ident;
  } tbl_upd_t;

endpackage

@@ hdl/ift_ram.sv @@
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module ift_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/ift_lookup.sv @@
// Key store of the reassembly table: valid bits, (source, id) keys, parallel match.
// Depends on ift_pkg.
module ift_lookup import ift_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] key_source,
  input  logic [15:0] key_ident,
  input  tbl_upd_t    upd,
  output lookup_t     lk
);
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]              src_r [TABLE_ENTRIES];
  logic [15:0]              id_r  [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (upd.release_entry) begin
      valid_r[upd.slot] <= 1'b0;
    end else if (upd.alloc) begin
      valid_r[upd.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.alloc) begin
      src_r[upd.slot] <= upd.source;
      id_r[upd.slot]  <= upd.ident;
    end
  end

  // lowest matching entry, lowest free entry
  always_comb begin
    lk = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && src_r[i] == key_source && id_r[i] == key_ident) begin
        lk.hit      = 1'b1;
        lk.hit_slot = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        lk.has_free  = 1'b1;
        lk.free_slot = IDX_W'(i);
      end
    end
  end
endmodule

@@ hdl/ipv4_fragment_reassembly_tracker.sv @@
// IPv4 receive filter and fragment reassembly tracker, top level.
// The result strobe comes from the output register, after stage 1; busy is high while stage 1
//   holds a header, so no new header is taken until it has left (table RAM read, then write-back).
// The receiver cannot stall: out_strobe is high for exactly one cycle.
// Synchronous reset clears the control and config registers and all table valid bits at once.
// Depends on ift_pkg, ift_ram, ift_lookup.
module ipv4_fragment_reassembly_tracker import ift_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] local_addr_r;
  logic [15:0] min_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      min_frame_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_ADDR: local_addr_r <= cfg_data;
        CFG_MIN_FRAME:  min_frame_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: checks and key lookup
  lookup_t  lk;
  tbl_upd_t upd;
  logic     accept;
  assign accept = start && !busy;

  ift_lookup u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_source (in_item.src_addr),
    .key_ident  (in_item.packet_id),
    .upd        (upd),
    .lk         (lk)
  );

  verdict_t         v0;
  route_t           route0;
  logic             use_tbl0;
  logic [IDX_W-1:0] slot0;
  logic             more0;
  logic [15:0]      off0, body0;
  logic [16:0]      fs_adj;

  always_comb begin
    unique case (in_item.protocol)
      PROTO_ICMP: route0 = R_ICMP;
      PROTO_UDP:  route0 = R_UDP;
      PROTO_TCP:  route0 = R_TCP;
      default:    route0 = R_OTHER;
    endcase
    more0  = in_item.frag_word[13];
    off0   = {in_item.frag_word[12:0], 3'b000};
    body0  = in_item.total_length - IP_HDR_BYTES;
    fs_adj = {1'b0, in_item.frame_size} - 17'(LINK_HEADER_BYTES);
    use_tbl0 = 1'b0;
    slot0    = lk.hit ? lk.hit_slot : lk.free_slot;
    if (in_item.version != IP_VERSION) begin
      v0 = V_BAD_VERSION;
    end else if (in_item.total_length < IP_HDR_BYTES) begin
      v0 = V_SHORT;
    end else if (in_item.frame_size > min_frame_r &&
                 (fs_adj[16] || {1'b0, in_item.total_length} != fs_adj)) begin
      v0 = V_BAD_LENGTH;
    end else if (in_item.dest_address != '0 && in_item.dest_address != '1 &&
                 in_item.dest_address != local_addr_r &&
                 !(in_item.protocol == PROTO_UDP &&
                   in_item.udp_dest_port == DHCP_CLIENT)) begin
      v0 = V_BAD_ADDR;
    end else if (!more0 && off0 == '0) begin
      v0 = V_DELIVER;
    end else if (!lk.hit && !lk.has_free) begin
      v0 = V_TABLE_FULL;
    end else begin
      v0       = V_HELD;
      use_tbl0 = 1'b1;
    end
  end

  // stage 1 registers
  logic             s1_valid_r;
  verdict_t         s1_v_r;
  route_t           s1_route_r;
  logic             s1_tbl_r, s1_new_r, s1_more_r;
  logic [IDX_W-1:0] s1_slot_r;
  logic [15:0]      s1_off_r, s1_body_r;
  logic [31:0]      s1_src_r;
  logic [15:0]      s1_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v_r     <= v0;
      s1_route_r <= route0;
      s1_tbl_r   <= use_tbl0;
      s1_new_r   <= !lk.hit;
      s1_more_r  <= more0;
      s1_slot_r  <= slot0;
      s1_off_r   <= off0;
      s1_body_r  <= body0;
      s1_src_r   <= in_item.src_addr;
      s1_id_r    <= in_item.packet_id;
    end
  end

  assign busy = s1_valid_r;

  // ---------------- counter RAM: {received, total}
  logic [2*CNT_W-1:0] rd_data, wr_data;
  logic               ram_we;

  ift_ram #(.WIDTH(2*CNT_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot_r),
    .wdata (wr_data),
    .raddr (slot0),
    .rdata (rd_data)
  );

  // ---------------- stage 1: update and verdict
  logic [CNT_W-1:0] old_rcv, old_tot, new_rcv, new_tot;
  verdict_t         v1;
  logic [15:0]      len1;
  logic             free1;

  always_comb begin
    old_rcv = s1_new_r ? '0 : rd_data[2*CNT_W-1:CNT_W];
    old_tot = s1_new_r ? '0 : rd_data[CNT_W-1:0];
    new_rcv = old_rcv + {1'b0, s1_body_r};
    new_tot = old_tot;
    v1      = s1_v_r;
    len1    = '0;
    free1   = 1'b0;
    if (s1_tbl_r) begin
      if (new_rcv[CNT_W-1]) begin
        v1    = V_OVERFLOW;
        free1 = 1'b1;
      end else if (!s1_more_r && old_tot != '0) begin
        v1    = V_DOUBLE_LAST;
        free1 = 1'b1;
      end else begin
        if (!s1_more_r) begin
          new_tot = {1'b0, s1_off_r} + {1'b0, s1_body_r};
        end
        if (new_tot != '0 && new_tot == new_rcv) begin
          v1    = V_COMPLETE;
          len1  = new_tot[15:0];
          free1 = 1'b1;
        end else if (new_tot != '0 && new_rcv > new_tot) begin
          v1    = V_EXCESS;
          free1 = 1'b1;
        end else begin
          v1 = V_HELD;
        end
      end
    end
    wr_data = {new_rcv, new_tot};
    ram_we  = s1_valid_r && s1_tbl_r;
    upd.alloc         = ram_we && s1_new_r && !free1;
    upd.release_entry = ram_we && free1;
    upd.slot          = s1_slot_r;
    upd.source        = s1_src_r;
    upd.ident         = s1_id_r;
  end

  // ---------------- output register
  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_item_r.verdict            <= v1;
      out_item_r.route              <= s1_route_r;
      out_item_r.slot               <= s1_tbl_r ? 4'(s1_slot_r) : 4'd0;
      out_item_r.frag_offset        <= (s1_v_r < V_DELIVER) ? 16'd0 : s1_off_r;
      out_item_r.body_size          <= (s1_v_r < V_DELIVER) ? 16'd0 : s1_body_r;
      out_item_r.reassembled_length <= len1;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the IPv4 fragment reassembly tracker.
// Drives headers through start/busy, predicts each verdict with a scoreboard class.
// Depends on ift_pkg and the ipv4_fragment_reassembly_tracker RTL.
`timescale 1ns / 1ps

import ift_pkg::*;

class frag_scoreboard;
  logic [31:0] local_addr;
  logic [15:0] min_frame;
  bit          valid_q[TABLE_ENTRIES];
  logic [31:0] src_q[TABLE_ENTRIES];
  logic [15:0] id_q[TABLE_ENTRIES];
  logic [16:0] rcvd_q[TABLE_ENTRIES];
  logic [16:0] total_q[TABLE_ENTRIES];
  out_item_t   pending[$];
  int          errors;
  int          checked;
  int          verdict_seen[16];

  function void clear_table();
    local_addr = '0;
    min_frame  = '0;
    foreach (valid_q[i]) begin
      valid_q[i] = 0;
      rcvd_q[i]  = '0;
      total_q[i] = '0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] data);
    if (idx == CFG_LOCAL_ADDR) local_addr = data;
    else if (idx == CFG_MIN_FRAME) min_frame = data[15:0];
  endfunction

  function route_t route_of(logic [7:0] proto);
    if (proto == PROTO_ICMP) return R_ICMP;
    if (proto == PROTO_UDP) return R_UDP;
    if (proto == PROTO_TCP) return R_TCP;
    return R_OTHER;
  endfunction

  // verdict for one header, updating the table copy
  function void note_header(in_item_t h);
    out_item_t   r;
    logic        more;
    logic [15:0] off;
    logic [15:0] body;
    int          slot;
    bit          hit;
    r = '0;
    r.route = route_of(h.protocol);
    more = h.frag_word[13];
    off  = {h.frag_word[12:0], 3'b000};
    body = h.total_length - IP_HDR_BYTES;
    slot = 0;
    hit  = 0;
    if (h.version != IP_VERSION) r.verdict = V_BAD_VERSION;
    else if (h.total_length < IP_HDR_BYTES) r.verdict = V_SHORT;
    else if (h.frame_size > min_frame &&
             (h.frame_size < LINK_HEADER_BYTES ||
              h.total_length != h.frame_size - LINK_HEADER_BYTES))
      r.verdict = V_BAD_LENGTH;
    else if (h.dest_address != 0 && h.dest_address != '1 && h.dest_address != local_addr &&
             !(h.protocol == PROTO_UDP && h.udp_dest_port == DHCP_CLIENT))
      r.verdict = V_BAD_ADDR;
    else begin
      r.frag_offset = off;
      r.body_size   = body;
      if (!more && off == 0) r.verdict = V_DELIVER;
      else begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (!hit && valid_q[i] && src_q[i] == h.src_addr && id_q[i] == h.packet_id) begin
            slot = i;
            hit = 1;
          end
        if (!hit) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!hit && !valid_q[i]) begin
              slot = i;
              hit = 1;
            end
          if (hit) begin
            valid_q[slot] = 1;
            src_q[slot]   = h.src_addr;
            id_q[slot]    = h.packet_id;
            rcvd_q[slot]  = '0;
            total_q[slot] = '0;
          end
        end
        if (!hit) r.verdict = V_TABLE_FULL;
        else begin
          r.slot = slot[3:0];
          rcvd_q[slot] = rcvd_q[slot] + body;
          r.verdict = V_HELD;
          if (rcvd_q[slot] > 17'hFFFF) begin
            valid_q[slot] = 0;
            r.verdict = V_OVERFLOW;
          end else if (!more && total_q[slot] != 0) begin
            valid_q[slot] = 0;
            r.verdict = V_DOUBLE_LAST;
          end else begin
            if (!more) total_q[slot] = {1'b0, off} + body;
            if (total_q[slot] != 0) begin
              if (total_q[slot] == rcvd_q[slot]) begin
                valid_q[slot] = 0;
                r.verdict = V_COMPLETE;
                r.reassembled_length = total_q[slot][15:0];
              end else if (rcvd_q[slot] > total_q[slot]) begin
                valid_q[slot] = 0;
                r.verdict = V_EXCESS;
              end
            end
          end
        end
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    checked++;
    verdict_seen[want.verdict]++;
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  frag_scoreboard sb;
  int idle_cycles;
  int sent;

  ipv4_fragment_reassembly_tracker uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
    if (!rst_n || out_strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_header(in_item_t h);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    start = 1;
    in_item = h;
    do @(posedge clk); while (busy);
    sb.note_header(h);
    sent++;
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // header built to pass the filter, unless its total length is under 20 or its frame size wraps
  function automatic in_item_t good_header(logic [31:0] src, logic [15:0] id,
                                           logic [15:0] word, logic [15:0] tlen);
    in_item_t h;
    h.version = IP_VERSION;
    h.total_length = tlen;
    h.frame_size = 16'(tlen + LINK_HEADER_BYTES);
    h.src_addr = src;
    h.dest_address = ($urandom_range(0, 1)) ? sb.local_addr : '1;
    h.protocol = ($urandom_range(0, 1)) ? PROTO_UDP : 8'($urandom);
    h.frag_word = {2'($urandom_range(0, 3)), 14'h0} | word;
    h.packet_id = id;
    h.udp_dest_port = 16'($urandom);
    return h;
  endfunction

  function automatic in_item_t noise_header();
    in_item_t     h;
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    h = bits[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 1)) h.version = IP_VERSION;
    if ($urandom_range(0, 2) == 0) h.protocol = PROTO_UDP;
    if ($urandom_range(0, 2) == 0) h.udp_dest_port = DHCP_CLIENT;
    if ($urandom_range(0, 2) == 0) h.dest_address = sb.local_addr;
    return h;
  endfunction

  // random datagram split into 8-byte-aligned fragments, sometimes broken
  task automatic send_datagram();
    logic [31:0] src;
    logic [15:0] id;
    int nfrag, chunk, offs, tl;
    src = $urandom_range(0, 3);
    id = 16'($urandom_range(0, 7));
    nfrag = $urandom_range(1, 4);
    offs = 0;
    for (int k = 0; k < nfrag; k++) begin
      chunk = 8 * $urandom_range(0, 40);
      if ($urandom_range(0, 30) == 0) chunk = 65512;
      tl = chunk + 20;
      send_header(good_header(src, id,
                  {2'b00, (k != nfrag - 1) ^ ($urandom_range(0, 9) == 0), 13'(offs / 8)},
                  16'(tl)));
      offs += chunk;
    end
  endtask

  initial begin
    in_item_t h;
    sb = new();
    sb.clear_table();
    rst_n = 0;
    start = 0;
    in_item = '0;
    cfg_we = 0;
    cfg_index = CFG_LOCAL_ADDR;
    cfg_data = '0;
    idle_cycles = 0;
    sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    write_reg(CFG_LOCAL_ADDR, 32'hC0A8_0001);
    write_reg(CFG_MIN_FRAME, 16'd0);
    // directed: filter extremes
    h = good_header(1, 1, 0, 20);
    h.version = 4'hF; send_header(h);
    h.version = 0; send_header(h);
    h = good_header(1, 1, 0, 19); h.frame_size = 33; send_header(h);
    h = good_header(1, 1, 0, 100); h.frame_size = 5; send_header(h);
    h = good_header(1, 1, 0, 100); h.frame_size = 115; send_header(h);
    h = good_header(1, 1, 0, 16'hFFFF); h.frame_size = 16'hFFFF; send_header(h);
    h = good_header(1, 1, 0, 40); h.dest_address = 32'h0A00_0001; h.protocol = PROTO_TCP;
    send_header(h);
    h.protocol = PROTO_UDP; h.udp_dest_port = DHCP_CLIENT; send_header(h);
    h.dest_address = 0; h.protocol = PROTO_ICMP; send_header(h);
    // directed: complete, double last, excess, overflow
    send_header(good_header(7, 7, 16'h2000, 36));
    send_header(good_header(7, 7, 16'h0002, 36));
    send_header(good_header(8, 8, 16'h0002, 36));
    send_header(good_header(8, 8, 16'h0004, 36));
    send_header(good_header(9, 9, 16'h0001, 36));
    send_header(good_header(9, 9, 16'h2000, 36));
    send_header(good_header(5, 5, 16'h3FFF, 16'hFFF0));
    send_header(good_header(5, 5, 16'h2000, 16'hFFF0));
    // fill table, then one more
    for (int i = 0; i < TABLE_ENTRIES + 1; i++)
      send_header(good_header(32'hAA00 + i, 16'hFFFF, 16'h2000, 28));
    drain();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_header(good_header(32'hAA00 + i, 16'hFFFF, 16'h0001, 28));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_LOCAL_ADDR, phase == 1 ? 32'hFFFF_FFFF : (phase == 2 ? 32'h0 : $urandom));
      write_reg(CFG_MIN_FRAME, phase == 1 ? 16'hFFFF : (phase == 2 ? 16'h0 : $urandom));
      while (sent < 100 * (phase + 1)) begin
        if ($urandom_range(0, 4) == 0) send_header(noise_header());
        else send_datagram();
      end
      drain();
    end

    $display("Covered %0d headers; verdict counts held=%0d complete=%0d full=%0d.",
             sent, sb.verdict_seen[V_HELD], sb.verdict_seen[V_COMPLETE],
             sb.verdict_seen[V_TABLE_FULL]);
    $display("Checked %0d results across four register settings.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

@@ ipv4_fragment_reassembly_tracker.f @@
hdl/ift_pkg.sv
hdl/ift_ram.sv
hdl/ift_lookup.sv
hdl/ipv4_fragment_reassembly_tracker.sv
dv/testbench.sv
